/* src/lfu_pkg.sv */
// shared constants and types for the lfu cache table
// slot storage layout, field widths and operation codes; no dependencies
`default_nettype none

package lfu_pkg;

    localparam int ENTRIES    = 16;
    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int OCC_BITS   = $clog2(ENTRIES + 1);
    localparam int COUNT_BITS = 16;
    localparam int KEY_BITS   = 32;
    localparam int DATA_BITS  = 32;
    localparam int LIMIT_BITS = 5;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(16);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_FIRST = COUNT_BITS'(1);

    // operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // one slot of the table memory
    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [DATA_BITS-1:0]  data;
        logic [COUNT_BITS-1:0] count;
    } slot_t;

endpackage

`default_nettype wire

/* src/lfu_cache_table_core.sv */
// lfu cache table: key-value store with least-frequently-used replacement
// depends on lfu_pkg for widths, slot layout and operation codes
`default_nettype none

// usage
//   input channel (in_valid / in_ready) carries one request word: operation
//   (get or put), key and value. output channel (out_valid / out_ready)
//   returns one result word per request: hit, read_value, evicted and
//   evicted_key.
//   the cfg port writes entry_limit with cfg_wr_en / cfg_wr_data; every write
//   empties the table. write it only while no request is in flight.
// timing
//   one request at a time. a request is accepted while idle, then every slot is
//   streamed out of the slot memory (one read a cycle, registered read port),
//   then the touched or inserted slot is written back and the result loaded.
//   the result shows on out_valid the cycle after the write-back, and
//   in_ready rises again in that same cycle.
// stalls
//   the result sits in an output register, so the next request is scanned
//   while an old result waits. if that result is still not taken when the
//   next write-back is due, the write-back waits until out_ready.
// reset
//   all slots invalid, occupancy 0, entry_limit 16; the slot memory is not reset

module lfu_cache_table_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // request channel
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                operation,
    input  wire logic signed [lfu_pkg::KEY_BITS-1:0]  key,
    input  wire logic signed [lfu_pkg::DATA_BITS-1:0] value,
    // result channel
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     hit,
    output logic signed [lfu_pkg::DATA_BITS-1:0]      read_value,
    output logic                                     evicted,
    output logic signed [lfu_pkg::KEY_BITS-1:0]       evicted_key,
    // entry_limit register
    input  wire logic                                cfg_wr_en,
    input  wire logic [lfu_pkg::LIMIT_BITS-1:0]       cfg_wr_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    localparam int IW = lfu_pkg::IDX_BITS;
    localparam int OW = lfu_pkg::OCC_BITS;

    state_t state_reg;

    // latched request word
    logic                          req_op_reg;
    logic [lfu_pkg::KEY_BITS-1:0]  req_key_reg;
    logic [lfu_pkg::DATA_BITS-1:0] req_value_reg;

    // slot memory and its read pipe
    lfu_pkg::slot_t slot_mem [lfu_pkg::ENTRIES];
    lfu_pkg::slot_t rd_data_reg;
    logic [IW:0]    scan_cnt_reg;
    logic           rd_live_reg;
    logic [IW-1:0]  rd_addr_reg;

    // per-slot flops
    logic [lfu_pkg::ENTRIES-1:0] valid_reg;
    logic [IW-1:0]               rank_reg [lfu_pkg::ENTRIES];
    logic [OW-1:0]               occ_reg;
    logic [lfu_pkg::LIMIT_BITS-1:0] limit_reg;

    // scan trackers
    logic                           match_found_reg;
    logic [IW-1:0]                  match_idx_reg;
    logic [lfu_pkg::DATA_BITS-1:0]  match_data_reg;
    logic [lfu_pkg::COUNT_BITS-1:0] match_count_reg;
    logic                           vic_found_reg;
    logic [IW-1:0]                  vic_idx_reg;
    logic [lfu_pkg::COUNT_BITS-1:0] vic_count_reg;
    logic [IW-1:0]                  vic_rank_reg;
    logic [lfu_pkg::KEY_BITS-1:0]   vic_key_reg;

    // output register
    logic                          out_valid_reg;
    logic                          hit_reg;
    logic [lfu_pkg::DATA_BITS-1:0] read_value_reg;
    logic                          evicted_reg;
    logic [lfu_pkg::KEY_BITS-1:0]  evicted_key_reg;

    // write-back decisions
    logic                           in_fire;
    logic                           scan_issue;
    logic [OW-1:0]                  eff_limit;
    logic                           free_found;
    logic [IW-1:0]                  free_idx;
    logic                           is_get;
    logic                           put_en;
    logic                           commit;
    logic                           do_touch;
    logic                           do_evict;
    logic                           do_insert;
    logic [IW-1:0]                  ins_idx;
    logic [IW-1:0]                  touch_rank;
    logic                           mem_we;
    logic [IW-1:0]                  mem_wa;
    lfu_pkg::slot_t                 mem_wd;
    logic [lfu_pkg::COUNT_BITS-1:0] count_inc;
    logic                           rd_slot_valid;
    logic [IW-1:0]                  rd_slot_rank;
    logic                           rd_better;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign scan_issue = (scan_cnt_reg < (IW + 1)'(lfu_pkg::ENTRIES));

    // limits above the table size saturate
    assign eff_limit = (limit_reg > lfu_pkg::LIMIT_BITS'(lfu_pkg::ENTRIES))
                     ? OW'(lfu_pkg::ENTRIES) : OW'(limit_reg);

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = lfu_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // victim compare on the word coming out of memory: lower count wins,
    // equal count goes to the older touch (higher rank)
    assign rd_slot_valid = valid_reg[rd_addr_reg];
    assign rd_slot_rank  = rank_reg[rd_addr_reg];
    assign rd_better = !vic_found_reg
                    || (rd_data_reg.count < vic_count_reg)
                    || ((rd_data_reg.count == vic_count_reg)
                        && (rd_slot_rank > vic_rank_reg));

    // write-back step
    always_comb
    begin
        is_get     = (req_op_reg == lfu_pkg::OP_GET);
        put_en     = (req_op_reg == lfu_pkg::OP_PUT) && (eff_limit != '0);
        commit     = (state_reg == ST_UPDATE) && (!out_valid_reg || out_ready);
        do_touch   = match_found_reg && (is_get || put_en);
        do_evict   = put_en && !match_found_reg && (occ_reg >= eff_limit)
                  && vic_found_reg;
        do_insert  = put_en && !match_found_reg && (do_evict || free_found);
        ins_idx    = do_evict ? vic_idx_reg : free_idx;
        touch_rank = rank_reg[match_idx_reg];
        count_inc  = (match_count_reg == lfu_pkg::COUNT_MAX)
                   ? match_count_reg : match_count_reg + 1'b1;

        mem_we = commit && (do_touch || do_insert);
        mem_wa = do_touch ? match_idx_reg : ins_idx;
        mem_wd.key = req_key_reg;
        if (do_touch)
        begin
            mem_wd.data  = is_get ? match_data_reg : req_value_reg;
            mem_wd.count = count_inc;
        end
        else
        begin
            mem_wd.data  = req_value_reg;
            mem_wd.count = lfu_pkg::COUNT_FIRST;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= slot_mem[scan_cnt_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            req_op_reg      <= lfu_pkg::OP_GET;
            req_key_reg     <= '0;
            req_value_reg   <= '0;
            scan_cnt_reg    <= '0;
            rd_live_reg     <= 1'b0;
            rd_addr_reg     <= '0;
            valid_reg       <= '0;
            occ_reg         <= '0;
            limit_reg       <= lfu_pkg::LIMIT_RESET;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            match_data_reg  <= '0;
            match_count_reg <= '0;
            vic_found_reg   <= 1'b0;
            vic_idx_reg     <= '0;
            vic_count_reg   <= '0;
            vic_rank_reg    <= '0;
            vic_key_reg     <= '0;
            out_valid_reg   <= 1'b0;
            hit_reg         <= 1'b0;
            read_value_reg  <= '0;
            evicted_reg     <= 1'b0;
            evicted_key_reg <= '0;
            for (int i = 0; i < lfu_pkg::ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready && !commit)
            begin
                out_valid_reg <= 1'b0;
            end

            // a limit write empties the table
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
                valid_reg <= '0;
                occ_reg   <= '0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        req_op_reg      <= operation;
                        req_key_reg     <= key;
                        req_value_reg   <= value;
                        scan_cnt_reg    <= '0;
                        rd_live_reg     <= 1'b0;
                        match_found_reg <= 1'b0;
                        vic_found_reg   <= 1'b0;
                        state_reg       <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    rd_live_reg <= scan_issue;
                    rd_addr_reg <= scan_cnt_reg[IW-1:0];
                    if (scan_issue)
                    begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_UPDATE;
                    end

                    if (rd_live_reg && rd_slot_valid)
                    begin
                        if (rd_data_reg.key == req_key_reg)
                        begin
                            match_found_reg <= 1'b1;
                            match_idx_reg   <= rd_addr_reg;
                            match_data_reg  <= rd_data_reg.data;
                            match_count_reg <= rd_data_reg.count;
                        end
                        if (rd_better)
                        begin
                            vic_found_reg <= 1'b1;
                            vic_idx_reg   <= rd_addr_reg;
                            vic_count_reg <= rd_data_reg.count;
                            vic_rank_reg  <= rd_slot_rank;
                            vic_key_reg   <= rd_data_reg.key;
                        end
                    end
                end

                ST_UPDATE:
                begin
                    if (commit)
                    begin
                        out_valid_reg   <= 1'b1;
                        hit_reg         <= do_touch;
                        read_value_reg  <= (is_get && match_found_reg)
                                         ? match_data_reg : '0;
                        evicted_reg     <= do_evict;
                        evicted_key_reg <= do_evict ? vic_key_reg : '0;
                        state_reg       <= ST_IDLE;

                        if (do_touch)
                        begin
                            // touched entry becomes newest, newer ones age by one
                            for (int i = 0; i < lfu_pkg::ENTRIES; i++)
                            begin
                                if (IW'(i) == match_idx_reg)
                                begin
                                    rank_reg[i] <= '0;
                                end
                                else if (valid_reg[i] && (rank_reg[i] < touch_rank))
                                begin
                                    rank_reg[i] <= rank_reg[i] + 1'b1;
                                end
                            end
                        end
                        else if (do_insert)
                        begin
                            // eviction closes the victim's rank gap, then all age
                            for (int i = 0; i < lfu_pkg::ENTRIES; i++)
                            begin
                                if (IW'(i) == ins_idx)
                                begin
                                    rank_reg[i] <= '0;
                                end
                                else if (valid_reg[i] && !(do_evict
                                    && (rank_reg[i] > vic_rank_reg)))
                                begin
                                    rank_reg[i] <= rank_reg[i] + 1'b1;
                                end
                            end
                            valid_reg[ins_idx] <= 1'b1;
                            if (!do_evict)
                            begin
                                occ_reg <= occ_reg + 1'b1;
                            end
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

endmodule

`default_nettype wire
